// ===== hdl/flip_digit_animation_sequencer_unit_macros.svh =====
`ifndef FLIP_DIGIT_ANIMATION_SEQUENCER_UNIT_MACROS_SVH
`define FLIP_DIGIT_ANIMATION_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FDAS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FDAS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/fdas_pkg.sv =====
package fdas_pkg;

  localparam int NUM_SLOTS = 6;
  localparam int MAX_SLOTS = 8;
  localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  localparam logic [15:0] FRAME_PERIOD_RST = 16'd35;
  localparam logic [3:0]  FLIP_LENGTH_RST  = 4'd8;

  typedef enum logic {
    OP_TIME  = 1'b0,
    OP_FRAME = 1'b1
  } opcode_t;

  typedef enum logic {
    CFG_FRAME_PERIOD = 1'b0,
    CFG_FLIP_LENGTH  = 1'b1
  } cfg_addr_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    logic [31:0] now_ms;
  } in_req_t;

  typedef struct packed {
    logic [2:0] digit_position;
    logic [3:0] shown_digit;
    logic [3:0] old_digit;
    logic [3:0] flip_frame;
    logic       last_of_run;
  } out_res_t;

  // Splits a value below 64 into its tens and units digits.
  function automatic logic [7:0] split_tu(input logic [5:0] v);
    logic [2:0] tens;
    logic [5:0] units;
    tens = 3'd0;
    for (int k = 1; k <= 6; k++) begin
      if (v >= 6'(k * 10)) begin
        tens = 3'(k);
      end
    end
    units = v - 6'(tens * 4'd10);
    return {1'b0, tens, units[3:0]};
  endfunction

endpackage

// ===== hdl/flip_digit_animation_sequencer_unit.sv =====
// Flip clock digit animation sequencer.
// The input channel (in_valid, in_ready, in_data) takes time requests and
// frame requests. A time request updates the stored digits and starts flips
// and produces no results. A frame request advances active flips when the
// frame period has elapsed and then produces one result per slot on the
// output channel (out_valid, out_ready, out_data), the first in the cycle
// after acceptance and one per cycle after that while out_ready is high, the
// last marked with last_of_run. No request is accepted while a run is
// being delivered, except that the next request is accepted in the same
// cycle that the final result is taken.
// The results come from a snapshot taken at acceptance, so a stalled
// receiver simply holds the current result until it is taken.
// The cfg_we, cfg_addr and cfg_wdata port writes frame_period_ms and
// flip_length. A synchronous reset clears all digits, flips and the advance
// timestamp and restores the register defaults.
module flip_digit_animation_sequencer_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fdas_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output fdas_pkg::out_res_t out_data,
  input  logic               cfg_we,
  input  fdas_pkg::cfg_addr_t cfg_addr,
  input  logic [15:0]        cfg_wdata
);
  import fdas_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  logic [15:0] period_r, period_nxt;
  logic [3:0]  flip_len_r, flip_len_nxt;
  logic [31:0] last_r, last_nxt;

  logic [3:0] time_r     [NUM_SLOTS];
  logic [3:0] time_nxt   [NUM_SLOTS];
  logic [3:0] settle_r   [NUM_SLOTS];
  logic [3:0] settle_nxt [NUM_SLOTS];
  logic [3:0] depart_r   [NUM_SLOTS];
  logic [3:0] depart_nxt [NUM_SLOTS];
  logic [3:0] fc_r       [NUM_SLOTS];
  logic [3:0] fc_nxt     [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] seen_r, seen_nxt;

  logic [3:0] snap_shown_r   [NUM_SLOTS];
  logic [3:0] snap_shown_nxt [NUM_SLOTS];
  logic [3:0] snap_old_r     [NUM_SLOTS];
  logic [3:0] snap_old_nxt   [NUM_SLOTS];
  logic [3:0] snap_frame_r   [NUM_SLOTS];
  logic [3:0] snap_frame_nxt [NUM_SLOTS];

  logic             busy_r, busy_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  logic       time_fire;
  logic       frame_fire;
  logic       last_take;
  logic       advance;
  logic [31:0] elapsed;
  logic [7:0] hs, ms, ss;
  logic [3:0] dig [MAX_SLOTS];
  logic [4:0] f5;

  assign last_take  = busy_r && out_ready && (idx_r == LAST_IDX);
  assign in_ready   = !busy_r || last_take;
  assign time_fire  = in_valid && in_ready && (in_data.opcode == OP_TIME);
  assign frame_fire = in_valid && in_ready && (in_data.opcode == OP_FRAME);
  assign elapsed    = in_data.now_ms - last_r;
  assign advance    = elapsed >= {16'd0, period_r};

  assign hs = split_tu({1'b0, in_data.hours});
  assign ms = split_tu(in_data.minutes);
  assign ss = split_tu(in_data.seconds);

  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      dig[i] = 4'd0;
    end
    dig[0] = hs[7:4];
    dig[1] = hs[3:0];
    dig[2] = ms[7:4];
    dig[3] = ms[3:0];
    dig[4] = ss[7:4];
    dig[5] = ss[3:0];
  end

  always_comb begin
    period_nxt   = period_r;
    flip_len_nxt = flip_len_r;
    last_nxt     = last_r;
    seen_nxt     = seen_r;
    busy_nxt     = busy_r;
    idx_nxt      = idx_r;
    f5           = 5'd0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      time_nxt[i]       = time_r[i];
      settle_nxt[i]     = settle_r[i];
      depart_nxt[i]     = depart_r[i];
      fc_nxt[i]         = fc_r[i];
      snap_shown_nxt[i] = snap_shown_r[i];
      snap_old_nxt[i]   = snap_old_r[i];
      snap_frame_nxt[i] = snap_frame_r[i];
    end

    if (cfg_we) begin
      case (cfg_addr)
        CFG_FRAME_PERIOD: period_nxt   = cfg_wdata;
        CFG_FLIP_LENGTH:  flip_len_nxt = cfg_wdata[3:0];
        default: ;
      endcase
    end

    if (time_fire) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        time_nxt[i] = dig[i];
        if (!seen_r[i]) begin
          settle_nxt[i] = dig[i];
          depart_nxt[i] = dig[i];
          seen_nxt[i]   = 1'b1;
        end else if (dig[i] != settle_r[i] && fc_r[i] == 4'd0) begin
          depart_nxt[i] = settle_r[i];
          settle_nxt[i] = dig[i];
          fc_nxt[i]     = 4'd1;
        end
      end
    end

    if (frame_fire) begin
      if (advance) begin
        last_nxt = in_data.now_ms;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (fc_r[i] != 4'd0) begin
            f5 = {1'b0, fc_r[i]} + 5'd1;
            fc_nxt[i] = (f5 > {1'b0, flip_len_r} || f5 > 5'd15) ? 4'd0 : f5[3:0];
          end
        end
      end
      for (int i = 0; i < NUM_SLOTS; i++) begin
        snap_shown_nxt[i] = time_r[i];
        snap_old_nxt[i]   = seen_r[i] ? depart_r[i] : time_r[i];
        snap_frame_nxt[i] = fc_nxt[i];
      end
    end

    if (busy_r && out_ready) begin
      idx_nxt = idx_r + IDX_W'(1);
      if (idx_r == LAST_IDX) begin
        busy_nxt = 1'b0;
        idx_nxt  = '0;
      end
    end
    if (frame_fire) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r   <= FRAME_PERIOD_RST;
      flip_len_r <= FLIP_LENGTH_RST;
      last_r     <= '0;
      seen_r     <= '0;
      busy_r     <= 1'b0;
      idx_r      <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        time_r[i]   <= '0;
        settle_r[i] <= '0;
        depart_r[i] <= '0;
        fc_r[i]     <= '0;
      end
    end else begin
      period_r   <= period_nxt;
      flip_len_r <= flip_len_nxt;
      last_r     <= last_nxt;
      seen_r     <= seen_nxt;
      busy_r     <= busy_nxt;
      idx_r      <= idx_nxt;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        time_r[i]   <= time_nxt[i];
        settle_r[i] <= settle_nxt[i];
        depart_r[i] <= depart_nxt[i];
        fc_r[i]     <= fc_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      snap_shown_r[i] <= snap_shown_nxt[i];
      snap_old_r[i]   <= snap_old_nxt[i];
      snap_frame_r[i] <= snap_frame_nxt[i];
    end
  end

  assign out_valid               = busy_r;
  assign out_data.digit_position = 3'(idx_r);
  assign out_data.shown_digit    = snap_shown_r[idx_r];
  assign out_data.old_digit      = snap_old_r[idx_r];
  assign out_data.flip_frame     = snap_frame_r[idx_r];
  assign out_data.last_of_run    = (idx_r == LAST_IDX);

`include "flip_digit_animation_sequencer_unit_macros.svh"

  `FDAS_ASSERT_NEXT(a_frame_starts_run, frame_fire, out_valid && idx_r == '0,
    "frame request did not start a result run at slot zero")
  `FDAS_ASSERT_NEXT(a_run_ends, last_take && !frame_fire, !out_valid,
    "results continued past the last slot")
  `FDAS_ASSERT_NEXT(a_stall_holds_slot, out_valid && !out_ready,
    out_valid && $stable(idx_r), "slot index moved while the receiver stalled")
  `FDAS_ASSERT_NOW(a_idx_in_range, out_valid, idx_r <= LAST_IDX,
    "slot index beyond the last slot")

endmodule
